[rtl/core/ccc_pkg.sv]
// Shared types, sizes and codes for the callsign coordinate cache.
package ccc_pkg;

  localparam int CacheEntries = 256;
  localparam int PendEntries  = 32;
  localparam int CIdxW = $clog2(CacheEntries);
  localparam int PIdxW = (PendEntries > 1) ? $clog2(PendEntries) : 1;

  // request type codes on the input channel
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;

  // lookup status codes
  localparam logic [1:0] HIT_NONE    = 2'd0;
  localparam logic [1:0] HIT_NOCOORD = 2'd1;
  localparam logic [1:0] HIT_COORD   = 2'd2;

  // miss queue codes
  localparam logic [1:0] ENQ_NONE = 2'd0;
  localparam logic [1:0] ENQ_NEW  = 2'd1;
  localparam logic [1:0] ENQ_DUP  = 2'd2;
  localparam logic [1:0] ENQ_FULL = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOOKUP,
    OP_STORE,
    OP_POP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSCAN,
    ST_PSCAN,
    ST_PREAD,
    ST_PPOP,
    ST_DONE
  } st_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] kh;
    logic [55:0] kl;
    logic        has;
    logic [31:0] lat;
    logic [31:0] lon;
  } req_t;

  typedef struct packed {
    logic [1:0]  hit;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [1:0]  enq;
    logic        popv;
    logic [63:0] pkh;
    logic [55:0] pkl;
  } res_t;

endpackage

[rtl/core/ccc_front.sv]
// Intake: accepts request beats, classifies them and queues them for the engine.
module ccc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  input  logic [63:0]   key_high_i,
  input  logic [55:0]   key_low_i,
  input  logic          store_has_coords_i,
  input  logic [31:0]   store_lat_i,
  input  logic [31:0]   store_lon_i,
  output logic          q_valid_o,
  output ccc_pkg::req_t q_req_o,
  input  logic          q_take_i
);
  import ccc_pkg::*;

  req_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  req_t       cls;
  logic       push, pop;

  // classify: disabled or all-zero lookups need no work
  always_comb begin
    cls.kh  = key_high_i;
    cls.kl  = key_low_i;
    cls.has = store_has_coords_i;
    cls.lat = store_lat_i;
    cls.lon = store_lon_i;
    unique case (req_type_i)
      REQ_LOOKUP: cls.op = (enable_i && (key_high_i != '0 || key_low_i != '0))
                           ? OP_LOOKUP : OP_NONE;
      REQ_STORE:  cls.op = OP_STORE;
      REQ_POP:    cls.op = OP_POP;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_take_i;
  assign q_req_o    = fifo_q[rptr_q];

  // hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/ccc_back.sv]
// Engine: scans the cache and pending table, updates them and holds the result.
module ccc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ccc_pkg::req_t q_req_i,
  output logic          q_take_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ccc_pkg::res_t res_o
);
  import ccc_pkg::*;

  localparam logic [CIdxW:0]   CEnd  = (CIdxW + 1)'(CacheEntries);
  localparam logic [CIdxW-1:0] CLast = CIdxW'(CacheEntries - 1);
  localparam logic [PIdxW:0]   PEnd  = (PIdxW + 1)'(PendEntries);
  localparam logic [PIdxW-1:0] PLast = PIdxW'(PendEntries - 1);

  // cache store
  logic [63:0] c_kh_mem  [CacheEntries];
  logic [55:0] c_kl_mem  [CacheEntries];
  logic        c_has_mem [CacheEntries];
  logic [31:0] c_lat_mem [CacheEntries];
  logic [31:0] c_lon_mem [CacheEntries];
  logic [CacheEntries-1:0] c_valid_q;
  logic [CIdxW-1:0] rp_q;

  // pending table
  logic [63:0] p_kh_mem [PendEntries];
  logic [55:0] p_kl_mem [PendEntries];
  logic [PendEntries-1:0] p_valid_q;

  st_e  state_q, state_d;
  req_t cur_q;
  res_t res_q, res_d;

  logic [CIdxW:0]   ciss_q;
  logic             cs1_v_q;
  logic [CIdxW-1:0] cs1_idx_q;
  logic [CIdxW-1:0] caddr;
  logic [63:0]      crd_kh_q;
  logic [55:0]      crd_kl_q;
  logic             crd_has_q, crd_vld_q;
  logic [31:0]      crd_lat_q, crd_lon_q;

  logic [PIdxW:0]   piss_q;
  logic             ps1_v_q;
  logic [PIdxW-1:0] ps1_idx_q;
  logic [PIdxW-1:0] paddr, pop_idx_q;
  logic [63:0]      prd_kh_q;
  logic [55:0]      prd_kl_q;
  logic             prd_vld_q;

  logic             cmatch, clast, pmatch, plast;
  logic             cw_en, pw_en, p_clr, rp_inc;
  logic [CIdxW-1:0] cw_idx;
  logic             free_any, used_any;
  logic [PIdxW-1:0] free_idx, used_idx;

  assign caddr = ciss_q[CIdxW-1:0];
  assign paddr = (state_q == ST_PREAD) ? pop_idx_q : piss_q[PIdxW-1:0];

  assign cmatch = cs1_v_q && crd_vld_q && crd_kh_q == cur_q.kh && crd_kl_q == cur_q.kl;
  assign clast  = cs1_v_q && cs1_idx_q == CLast;
  assign pmatch = ps1_v_q && prd_vld_q && prd_kh_q == cur_q.kh && prd_kl_q == cur_q.kl;
  assign plast  = ps1_v_q && ps1_idx_q == PLast;

  // find lowest free and lowest used pending slot
  always_comb begin
    free_any = 1'b0;
    used_any = 1'b0;
    free_idx = '0;
    used_idx = '0;
    for (int i = PendEntries - 1; i >= 0; i--) begin
      if (!p_valid_q[i]) begin
        free_any = 1'b1;
        free_idx = PIdxW'(i);
      end else begin
        used_any = 1'b1;
        used_idx = PIdxW'(i);
      end
    end
  end

  // sequence one request
  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    q_take_o = 1'b0;
    cw_en    = 1'b0;
    cw_idx   = cs1_idx_q;
    pw_en    = 1'b0;
    p_clr    = 1'b0;
    rp_inc   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_take_o = 1'b1;
          res_d    = '0;
          unique case (q_req_i.op)
            OP_LOOKUP, OP_STORE: state_d = ST_CSCAN;
            OP_POP:              state_d = used_any ? ST_PREAD : ST_DONE;
            default:             state_d = ST_DONE;
          endcase
        end
      end
      ST_CSCAN: begin
        if (cmatch) begin
          state_d = ST_DONE;
          if (cur_q.op == OP_STORE) begin
            cw_en = 1'b1;
          end else if (crd_has_q) begin
            res_d.hit = HIT_COORD;
            res_d.lat = crd_lat_q;
            res_d.lon = crd_lon_q;
          end else begin
            res_d.hit = HIT_NOCOORD;
          end
        end else if (clast) begin
          if (cur_q.op == OP_STORE) begin
            cw_en   = 1'b1;
            cw_idx  = rp_q;
            rp_inc  = 1'b1;
            state_d = ST_DONE;
          end else begin
            state_d = ST_PSCAN;
          end
        end
      end
      ST_PSCAN: begin
        if (pmatch) begin
          res_d.enq = ENQ_DUP;
          state_d   = ST_DONE;
        end else if (plast) begin
          pw_en     = free_any;
          res_d.enq = free_any ? ENQ_NEW : ENQ_FULL;
          state_d   = ST_DONE;
        end
      end
      ST_PREAD: state_d = ST_PPOP;
      ST_PPOP: begin
        p_clr      = 1'b1;
        res_d.popv = 1'b1;
        res_d.pkh  = prd_kh_q;
        res_d.pkl  = prd_kl_q;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // cache memory read and write
  always_ff @(posedge clk_i) begin
    crd_kh_q  <= c_kh_mem[caddr];
    crd_kl_q  <= c_kl_mem[caddr];
    crd_has_q <= c_has_mem[caddr];
    crd_lat_q <= c_lat_mem[caddr];
    crd_lon_q <= c_lon_mem[caddr];
    if (cw_en) begin
      c_kh_mem[cw_idx]  <= cur_q.kh;
      c_kl_mem[cw_idx]  <= cur_q.kl;
      c_has_mem[cw_idx] <= cur_q.has;
      c_lat_mem[cw_idx] <= cur_q.lat;
      c_lon_mem[cw_idx] <= cur_q.lon;
    end
  end

  // pending memory read and write
  always_ff @(posedge clk_i) begin
    prd_kh_q <= p_kh_mem[paddr];
    prd_kl_q <= p_kl_mem[paddr];
    if (pw_en) begin
      p_kh_mem[free_idx] <= cur_q.kh;
      p_kl_mem[free_idx] <= cur_q.kl;
    end
  end

  // hold request and result payload
  always_ff @(posedge clk_i) begin
    if (q_take_o) cur_q <= q_req_i;
    if (state_q == ST_IDLE && q_valid_i) pop_idx_q <= used_idx;
    res_q     <= res_d;
    cs1_idx_q <= caddr;
    ps1_idx_q <= piss_q[PIdxW-1:0];
    crd_vld_q <= c_valid_q[caddr];
    prd_vld_q <= p_valid_q[paddr];
  end

  // advance control state, scan counters and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ciss_q    <= '0;
      piss_q    <= '0;
      cs1_v_q   <= 1'b0;
      ps1_v_q   <= 1'b0;
      c_valid_q <= '0;
      p_valid_q <= '0;
      rp_q      <= '0;
    end else begin
      state_q <= state_d;
      cs1_v_q <= (state_q == ST_CSCAN) && (ciss_q != CEnd);
      ps1_v_q <= (state_q == ST_PSCAN) && (piss_q != PEnd);
      if (state_q != ST_CSCAN)  ciss_q <= '0;
      else if (ciss_q != CEnd)  ciss_q <= ciss_q + 1'b1;
      if (state_q != ST_PSCAN)  piss_q <= '0;
      else if (piss_q != PEnd)  piss_q <= piss_q + 1'b1;
      if (cw_en)  c_valid_q[cw_idx] <= 1'b1;
      if (rp_inc) rp_q <= rp_q + 1'b1;
      if (pw_en)  p_valid_q[free_idx] <= 1'b1;
      if (p_clr)  p_valid_q[pop_idx_q] <= 1'b0;
    end
  end

endmodule

[rtl/core/callsign_coord_cache.sv]
// Top level of the callsign coordinate cache with miss queue.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  in       | input     | in_valid_i/in_stall_o  | req_type, key, store data
//  out      | output    | out_valid_o/out_stall_i| hit, lat/lon, enqueue, pop key
//  config   | input     | lookup_enable_we_i     | lookup_enable_i
//
// A lookup or store scans the 256 cache entries through the one read port,
// one a cycle, and stops at a hit; a lookup miss adds a 32-slot pending scan.
// A pop reads and clears the lowest used pending slot; a skipped request goes
// straight to the output beat. Reset clears all valid bits at once; no clearing
// pass. A stalled output holds the engine; the 2-beat intake queue can still fill.
module callsign_coord_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        lookup_enable_we_i,
  input  logic        lookup_enable_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] key_high_i,
  input  logic [55:0] key_low_i,
  input  logic        store_has_coords_i,
  input  logic [31:0] store_lat_i,
  input  logic [31:0] store_lon_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  hit_status_o,
  output logic [31:0] out_lat_o,
  output logic [31:0] out_lon_o,
  output logic [1:0]  enqueue_result_o,
  output logic        pop_valid_o,
  output logic [63:0] pop_key_high_o,
  output logic [55:0] pop_key_low_o
);
  import ccc_pkg::*;

  logic lookup_enable_q;
  logic q_valid, q_take;
  req_t q_req;
  res_t res;

  // hold enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookup_enable_q <= 1'b0;
    end else if (lookup_enable_we_i) begin
      lookup_enable_q <= lookup_enable_i;
    end
  end

  ccc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .enable_i           (lookup_enable_q),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .key_high_i         (key_high_i),
    .key_low_i          (key_low_i),
    .store_has_coords_i (store_has_coords_i),
    .store_lat_i        (store_lat_i),
    .store_lon_i        (store_lon_i),
    .q_valid_o          (q_valid),
    .q_req_o            (q_req),
    .q_take_i           (q_take)
  );

  ccc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_req_i     (q_req),
    .q_take_o    (q_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign hit_status_o     = res.hit;
  assign out_lat_o        = res.lat;
  assign out_lon_o        = res.lon;
  assign enqueue_result_o = res.enq;
  assign pop_valid_o      = res.popv;
  assign pop_key_high_o   = res.pkh;
  assign pop_key_low_o    = res.pkl;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the callsign coordinate cache with miss queue.
module testbench;
  import ccc_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [63:0] kh;
    logic [55:0] kl;
    logic        has;
    logic [31:0] lat;
    logic [31:0] lon;
  } beat_t;

  typedef struct packed {
    logic [1:0]  hit;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [1:0]  enq;
    logic        popv;
    logic [63:0] pkh;
    logic [55:0] pkl;
  } answer_t;

  // Directed row: a beat, an optional typed-in answer
  typedef struct {
    beat_t   b;
    bit      fixed;
    answer_t ans;
  } row_t;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        lookup_enable_we_i = 1'b0;
  logic        lookup_enable_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [63:0] key_high_i = '0;
  logic [55:0] key_low_i = '0;
  logic        store_has_coords_i = 1'b0;
  logic [31:0] store_lat_i = '0;
  logic [31:0] store_lon_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  hit_status_o;
  logic [31:0] out_lat_o;
  logic [31:0] out_lon_o;
  logic [1:0]  enqueue_result_o;
  logic        pop_valid_o;
  logic [63:0] pop_key_high_o;
  logic [55:0] pop_key_low_o;

  callsign_coord_cache dut (
    .clk_i, .rst_ni, .lookup_enable_we_i, .lookup_enable_i,
    .in_valid_i, .in_stall_o, .req_type_i, .key_high_i, .key_low_i,
    .store_has_coords_i, .store_lat_i, .store_lon_i,
    .out_valid_o, .out_stall_i, .hit_status_o, .out_lat_o, .out_lon_o,
    .enqueue_result_o, .pop_valid_o, .pop_key_high_o, .pop_key_low_o
  );

  // Shadow copy of the cache state
  logic        enable_q;
  logic [63:0] ekh [CacheEntries];
  logic [55:0] ekl [CacheEntries];
  logic        ev [CacheEntries];
  logic        ehas [CacheEntries];
  logic [31:0] elat [CacheEntries];
  logic [31:0] elon [CacheEntries];
  int          repl_ptr;
  logic [63:0] pkh [PendEntries];
  logic [55:0] pkl [PendEntries];
  logic        pv [PendEntries];

  answer_t expected_answers[$];
  int      errors = 0;
  bit      hold_off = 1'b0;

  // Known callsign keys reused so that hits, duplicates and updates happen
  logic [63:0] pool_kh [16];
  logic [55:0] pool_kl [16];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_cache_state();
    enable_q = 1'b0;
    repl_ptr = 0;
    for (int i = 0; i < CacheEntries; i++) ev[i] = 1'b0;
    for (int i = 0; i < PendEntries; i++) pv[i] = 1'b0;
  endfunction

  function automatic int find_key(logic [63:0] kh, logic [55:0] kl);
    for (int i = 0; i < CacheEntries; i++)
      if (ev[i] && ekh[i] == kh && ekl[i] == kl) return i;
    return -1;
  endfunction

  function automatic logic [1:0] queue_miss(logic [63:0] kh, logic [55:0] kl);
    int slot;
    slot = -1;
    for (int i = 0; i < PendEntries; i++) begin
      if (pv[i]) begin
        if (pkh[i] == kh && pkl[i] == kl) return ENQ_DUP;
      end else if (slot < 0) begin
        slot = i;
      end
    end
    if (slot < 0) return ENQ_FULL;
    pkh[slot] = kh;
    pkl[slot] = kl;
    pv[slot] = 1'b1;
    return ENQ_NEW;
  endfunction

  // Compute the answer to one beat and advance the shadow state
  function automatic answer_t serve_request(beat_t b);
    answer_t a;
    int idx;
    a = '{hit: HIT_NONE, lat: '0, lon: '0, enq: ENQ_NONE, popv: 1'b0,
          pkh: '0, pkl: '0};
    case (b.req)
      REQ_LOOKUP: begin
        if (enable_q && (b.kh != '0 || b.kl != '0)) begin
          idx = find_key(b.kh, b.kl);
          if (idx < 0) a.enq = queue_miss(b.kh, b.kl);
          else if (ehas[idx]) begin
            a.hit = HIT_COORD;
            a.lat = elat[idx];
            a.lon = elon[idx];
          end else a.hit = HIT_NOCOORD;
        end
      end
      REQ_STORE: begin
        idx = find_key(b.kh, b.kl);
        if (idx < 0) begin
          idx = repl_ptr;
          repl_ptr = (repl_ptr + 1) % CacheEntries;
        end
        ekh[idx] = b.kh;
        ekl[idx] = b.kl;
        ehas[idx] = b.has;
        elat[idx] = b.lat;
        elon[idx] = b.lon;
        ev[idx] = 1'b1;
      end
      REQ_POP: begin
        for (int i = 0; i < PendEntries; i++) begin
          if (pv[i]) begin
            pv[i] = 1'b0;
            a.popv = 1'b1;
            a.pkh = pkh[i];
            a.pkl = pkl[i];
            break;
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // Drive one beat, hold it until accepted; sender gaps come from the caller
  task automatic send_beat(beat_t b, bit fixed, answer_t ans);
    answer_t p;
    in_valid_i <= 1'b1;
    req_type_i <= b.req;
    key_high_i <= b.kh;
    key_low_i <= b.kl;
    store_has_coords_i <= b.has;
    store_lat_i <= b.lat;
    store_lon_i <= b.lon;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = serve_request(b);
    if (fixed && p != ans) begin
      $error("table row answer differs from predictor");
      errors++;
    end
    expected_answers.push_back(p);
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard;
    idle_sender(1);
    guard = 0;
    while (expected_answers.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    // every request type answers, so the expectation queue empties once all results are in
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_enable(logic v);
    lookup_enable_we_i <= 1'b1;
    lookup_enable_i <= v;
    @(posedge clk_i);
    lookup_enable_we_i <= 1'b0;
    enable_q = v;
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int k;
    int sel;
    sel = $urandom_range(99);
    b.req = (sel < 45) ? REQ_LOOKUP : (sel < 75) ? REQ_STORE :
            (sel < 97) ? REQ_POP : REQ_UNUSED;
    k = $urandom_range(15);
    if ($urandom_range(9) < 8) begin
      b.kh = pool_kh[k];
      b.kl = pool_kl[k];
    end else if ($urandom_range(19) == 0) begin
      b.kh = '0;
      b.kl = '0;
    end else begin
      b.kh = {$urandom, $urandom};
      b.kl = 56'({$urandom, $urandom});
    end
    b.has = 1'($urandom_range(1));
    b.lat = $urandom;
    b.lon = $urandom;
    return b;
  endfunction

  // Receiver: random stall pattern, one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) out_stall_i <= 1'b1;
      else if (phase % 512 < 128) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(3) == 0);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = expected_answers.pop_front();
        if (hit_status_o !== e.hit) begin
          $error("hit_status expected %0d got %0d", e.hit, hit_status_o); errors++;
        end
        if (out_lat_o !== e.lat) begin
          $error("out_lat expected %h got %h", e.lat, out_lat_o); errors++;
        end
        if (out_lon_o !== e.lon) begin
          $error("out_lon expected %h got %h", e.lon, out_lon_o); errors++;
        end
        if (enqueue_result_o !== e.enq) begin
          $error("enqueue_result expected %0d got %0d", e.enq, enqueue_result_o);
          errors++;
        end
        if (pop_valid_o !== e.popv) begin
          $error("pop_valid expected %0d got %0d", e.popv, pop_valid_o); errors++;
        end
        if (pop_key_high_o !== e.pkh) begin
          $error("pop_key_high expected %h got %h", e.pkh, pop_key_high_o); errors++;
        end
        if (pop_key_low_o !== e.pkl) begin
          $error("pop_key_low expected %h got %h", e.pkl, pop_key_low_o); errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    answer_t none;
    answer_t a;
    beat_t b;
    logic [63:0] kmax_h;
    logic [55:0] kmax_l;
    int sent;
    int burst;

    none = '{hit: HIT_NONE, lat: '0, lon: '0, enq: ENQ_NONE, popv: 1'b0,
             pkh: '0, pkl: '0};
    kmax_h = '1;
    kmax_l = '1;
    for (int i = 0; i < 16; i++) begin
      pool_kh[i] = {$urandom, $urandom};
      pool_kl[i] = 56'({$urandom, $urandom});
    end
    clear_cache_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabled block: lookups miss and queue nothing
    rows.push_back('{'{REQ_LOOKUP, kmax_h, kmax_l, 1'b0, '0, '0}, 1'b1, none});
    rows.push_back('{'{REQ_POP, '0, '0, 1'b0, '0, '0}, 1'b1, none});
    rows.push_back('{'{REQ_UNUSED, kmax_h, kmax_l, 1'b1, '1, '1}, 1'b1, none});
    foreach (rows[i]) send_beat(rows[i].b, rows[i].fixed, rows[i].ans);
    drain();
    rows.delete();
    write_enable(1'b1);

    // Enabled: zero key, miss, duplicate, store, hits, pops
    rows.push_back('{'{REQ_LOOKUP, '0, '0, 1'b0, '0, '0}, 1'b1, none});
    a = none; a.enq = ENQ_NEW;
    rows.push_back('{'{REQ_LOOKUP, kmax_h, kmax_l, 1'b0, '0, '0}, 1'b1, a});
    a.enq = ENQ_DUP;
    rows.push_back('{'{REQ_LOOKUP, kmax_h, kmax_l, 1'b0, '0, '0}, 1'b1, a});
    rows.push_back('{'{REQ_STORE, kmax_h, kmax_l, 1'b1, '1, '1}, 1'b1, none});
    a = none; a.hit = HIT_COORD; a.lat = '1; a.lon = '1;
    rows.push_back('{'{REQ_LOOKUP, kmax_h, kmax_l, 1'b0, '0, '0}, 1'b1, a});
    rows.push_back('{'{REQ_STORE, kmax_h, kmax_l, 1'b0, '0, '0}, 1'b1, none});
    a = none; a.hit = HIT_NOCOORD;
    rows.push_back('{'{REQ_LOOKUP, kmax_h, kmax_l, 1'b0, '0, '0}, 1'b1, a});
    a = none; a.popv = 1'b1; a.pkh = kmax_h; a.pkl = kmax_l;
    rows.push_back('{'{REQ_POP, '0, '0, 1'b0, '0, '0}, 1'b1, a});
    rows.push_back('{'{REQ_POP, '0, '0, 1'b0, '0, '0}, 1'b1, none});
    rows.push_back('{'{REQ_STORE, '0, '0, 1'b1, 32'h1, 32'h8000_0000}, 1'b0, none});
    rows.push_back('{'{REQ_LOOKUP, 64'h1, 56'h0, 1'b0, '0, '0}, 1'b0, none});
    rows.push_back('{'{REQ_LOOKUP, 64'h0, 56'h1, 1'b0, '0, '0}, 1'b0, none});
    foreach (rows[i]) send_beat(rows[i].b, rows[i].fixed, rows[i].ans);

    // Fill the pending table past full, then empty it
    for (int i = 0; i < PendEntries + 2; i++) begin
      b = '{REQ_LOOKUP, {32'hC0DE, 32'(i)}, 56'(i + 7), 1'b0, '0, '0};
      send_beat(b, 1'b0, none);
    end
    for (int i = 0; i < PendEntries + 1; i++)
      send_beat('{REQ_POP, '0, '0, 1'b0, '0, '0}, 1'b0, none);

    // Wrap the replacement pointer with distinct stores; hold the receiver off
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < CacheEntries + 4; i++) begin
      b = '{REQ_STORE, {$urandom, $urandom}, 56'({$urandom, $urandom}),
            1'($urandom), $urandom, $urandom};
      send_beat(b, 1'b0, none);
    end
    drain();

    // Random bursts, with enable toggled between phases
    sent = 0;
    while (sent < 1400) begin
      if (sent % 400 == 399) begin
        drain();
        write_enable(($urandom_range(3) != 0));
      end
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        send_beat(random_beat(), 1'b0, none);
        sent++;
      end
      if ($urandom_range(2) != 0) idle_sender($urandom_range(1, 40));
    end
    drain();
    write_enable(1'b0);
    send_beat('{REQ_LOOKUP, pool_kh[0], pool_kl[0], 1'b0, '0, '0}, 1'b0, none);
    drain();

    if (errors == 0 && expected_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ccc_pkg.sv
rtl/core/ccc_front.sv
rtl/core/ccc_back.sv
rtl/core/callsign_coord_cache.sv
tb/testbench.sv
